// ===== hw/rtl/bei_pkg.sv =====
package bei_pkg;

    // Field and state widths
    localparam int ID_W     = 11;
    localparam int BYTE_W   = 8;
    localparam int SPEED_W  = 14;
    localparam int VOLT_W   = 16;
    localparam int CUR_W    = 16;
    localparam int POWER_W  = 32;
    localparam int WH_W     = 32;
    localparam int RES_W    = 33;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Default scale: 0.001 W units times 3600 s per hour
    localparam int ENERGY_SCALE_DEF = 3600000;

    localparam logic [SPEED_W-1:0] THRESHOLD_RESET = 14'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_ID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_THRES = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_ACC    = 5'b00100,
        ST_NORM   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

// ===== hw/rtl/battery_energy_integrator.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    frame_id, speed bytes, pack_voltage, pack_current
// out       output     out_valid / out_ready  battery_frame_seen, power_now, *_energy_wh, speed_now
// cfg       input      cfg_write_en           cfg_index, cfg_data
//
// A speed frame or an unknown frame goes from IDLE straight to FINISH, skipping MUL, ACC and NORM.
// A battery frame passes MUL, ACC and NORM, where NORM takes k whole scale steps
// to bring the residual back into [-ENERGY_SCALE, ENERGY_SCALE]; k is up to
// about 600 at the default scale; the single 33-bit adder takes one step a cycle.
// One item is worked at a time; in_ready is low from transfer until the result is loaded.
// rst_n clears the architectural state, counters and residuals; the moving threshold resets to 10.
// A stalled result holds in the output register; a new item is taken meanwhile.
module battery_energy_integrator #(
    parameter int ENERGY_SCALE = bei_pkg::ENERGY_SCALE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write_en,
    input  logic [bei_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bei_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bei_pkg::ID_W-1:0]          frame_id,
    input  logic [bei_pkg::BYTE_W-1:0]        speed_low_byte,
    input  logic [bei_pkg::BYTE_W-1:0]        speed_high_byte,
    input  logic [bei_pkg::VOLT_W-1:0]        pack_voltage,
    input  logic signed [bei_pkg::CUR_W-1:0]  pack_current,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              battery_frame_seen,
    output logic signed [bei_pkg::POWER_W-1:0] power_now,
    output logic signed [bei_pkg::WH_W-1:0]   drive_energy_wh,
    output logic signed [bei_pkg::WH_W-1:0]   charge_energy_wh,
    output logic [bei_pkg::SPEED_W-1:0]       speed_now
);

    localparam int RES_W = bei_pkg::RES_W;
    localparam logic signed [RES_W-1:0] SCALE_POS = RES_W'(ENERGY_SCALE);
    localparam logic signed [RES_W-1:0] SCALE_NEG = -SCALE_POS;

    // Configuration registers
    logic [bei_pkg::ID_W-1:0]    speed_id_reg;
    logic [bei_pkg::ID_W-1:0]    battery_id_reg;
    logic [bei_pkg::SPEED_W-1:0] threshold_reg;

    // Architectural state
    logic [bei_pkg::SPEED_W-1:0]        speed_reg;
    logic signed [bei_pkg::POWER_W-1:0] power_reg;
    logic signed [RES_W-1:0]            drive_res_reg;
    logic signed [RES_W-1:0]            charge_res_reg;
    logic [bei_pkg::WH_W-1:0]           drive_wh_reg;
    logic [bei_pkg::WH_W-1:0]           charge_wh_reg;

    // Working registers
    bei_pkg::state_t                    state_reg, state_next;
    logic                               seen_reg;
    logic                               sel_drive_reg;
    logic [bei_pkg::VOLT_W-1:0]         volt_reg;
    logic signed [bei_pkg::CUR_W-1:0]   cur_reg;
    logic signed [RES_W-1:0]            acc_reg;

    // Output register
    logic                               out_valid_reg;
    logic                               out_seen_reg;
    logic signed [bei_pkg::POWER_W-1:0] out_power_reg;
    logic [bei_pkg::WH_W-1:0]           out_drive_reg;
    logic [bei_pkg::WH_W-1:0]           out_charge_reg;
    logic [bei_pkg::SPEED_W-1:0]        out_speed_reg;

    logic                               in_xfer;
    logic                               out_free;
    logic                               sel_drive_now;
    logic signed [RES_W-1:0]            add_a;
    logic signed [RES_W-1:0]            add_b;
    logic signed [RES_W-1:0]            add_sum;
    logic                               above_pos;
    logic                               below_neg;
    logic [bei_pkg::WH_W-1:0]           wh_cur;
    logic [bei_pkg::WH_W-1:0]           wh_step;

    logic signed [bei_pkg::POWER_W-1:0] product;

    assign in_ready = (state_reg == bei_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Multiply unsigned voltage by signed current; the product always fits in 32 bits
    assign product = bei_pkg::POWER_W'($signed({1'b0, volt_reg}))
                   * bei_pkg::POWER_W'(cur_reg);

    // Pick the residual for this power
    assign sel_drive_now = (speed_reg > threshold_reg) || (power_reg > 0);

    // Shared adder: add power to the residual, then step by the scale
    assign above_pos = acc_reg > SCALE_POS;
    assign below_neg = acc_reg < SCALE_NEG;

    always_comb
    begin
        if (state_reg == bei_pkg::ST_ACC)
        begin
            add_a = sel_drive_now ? drive_res_reg : charge_res_reg;
            add_b = RES_W'(power_reg);
        end
        else
        begin
            add_a = acc_reg;
            add_b = above_pos ? SCALE_NEG : SCALE_POS;
        end
    end

    assign add_sum = add_a + add_b;

    // Counter step for the selected residual
    assign wh_cur  = sel_drive_reg ? drive_wh_reg : charge_wh_reg;
    assign wh_step = above_pos ? (wh_cur + 32'd1) : (wh_cur - 32'd1);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bei_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (frame_id != speed_id_reg && frame_id == battery_id_reg)
                        state_next = bei_pkg::ST_MUL;
                    else
                        state_next = bei_pkg::ST_FINISH;
                end
            end
            bei_pkg::ST_MUL:    state_next = bei_pkg::ST_ACC;
            bei_pkg::ST_ACC:    state_next = bei_pkg::ST_NORM;
            bei_pkg::ST_NORM:
            begin
                if (!above_pos && !below_neg)
                    state_next = bei_pkg::ST_FINISH;
            end
            bei_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = bei_pkg::ST_IDLE;
            end
            default:            state_next = bei_pkg::ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_id_reg   <= '0;
            battery_id_reg <= '0;
            threshold_reg  <= bei_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                bei_pkg::CFG_SPEED_ID:     speed_id_reg   <= cfg_data[bei_pkg::ID_W-1:0];
                bei_pkg::CFG_BATTERY_ID:   battery_id_reg <= cfg_data[bei_pkg::ID_W-1:0];
                bei_pkg::CFG_MOVING_THRES: threshold_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // State and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bei_pkg::ST_IDLE;
            speed_reg      <= '0;
            power_reg      <= '0;
            drive_res_reg  <= '0;
            charge_res_reg <= '0;
            drive_wh_reg   <= '0;
            charge_wh_reg  <= '0;
            seen_reg       <= 1'b0;
            sel_drive_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                bei_pkg::ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        seen_reg <= (frame_id != speed_id_reg) && (frame_id == battery_id_reg);
                        if (frame_id == speed_id_reg)
                            speed_reg <= {speed_high_byte[5:0], speed_low_byte};
                    end
                end
                bei_pkg::ST_MUL:
                begin
                    power_reg <= product;
                end
                bei_pkg::ST_ACC:
                begin
                    sel_drive_reg <= sel_drive_now;
                end
                bei_pkg::ST_NORM:
                begin
                    if (above_pos || below_neg)
                    begin
                        if (sel_drive_reg)
                            drive_wh_reg <= wh_step;
                        else
                            charge_wh_reg <= wh_step;
                    end
                    else if (sel_drive_reg)
                        drive_res_reg <= acc_reg;
                    else
                        charge_res_reg <= acc_reg;
                end
                default: ;
            endcase
        end
    end

    // Operand and accumulator registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            volt_reg <= pack_voltage;
            cur_reg  <= pack_current;
        end
        if (state_reg == bei_pkg::ST_ACC ||
            (state_reg == bei_pkg::ST_NORM && (above_pos || below_neg)))
            acc_reg <= add_sum;
    end

    // Load result into output register, drop it on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == bei_pkg::ST_FINISH && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bei_pkg::ST_FINISH && out_free)
        begin
            out_seen_reg   <= seen_reg;
            out_power_reg  <= power_reg;
            out_drive_reg  <= drive_wh_reg;
            out_charge_reg <= charge_wh_reg;
            out_speed_reg  <= speed_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign battery_frame_seen = out_seen_reg;
    assign power_now          = out_power_reg;
    assign drive_energy_wh    = out_drive_reg;
    assign charge_energy_wh   = out_charge_reg;
    assign speed_now          = out_speed_reg;

    // Residuals always sit inside the scale band
    a_drive_res_band: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_res_reg <= SCALE_POS) && (drive_res_reg >= SCALE_NEG))
        else $error("drive residual outside scale band");

    a_charge_res_band: assert property (@(posedge clk) disable iff (!rst_n)
        (charge_res_reg <= SCALE_POS) && (charge_res_reg >= SCALE_NEG))
        else $error("charge residual outside scale band");

    // Busy after an input transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input accepted while working");

    // A finished item always lands in the output register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bei_pkg::ST_FINISH && out_free) |=> out_valid_reg)
        else $error("result not loaded");

endmodule

// ===== bench/testbench.sv =====
module testbench;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     PRINT_LIMIT    = 100;
    localparam longint SCALE          = bei_pkg::ENERGY_SCALE_DEF;

    typedef struct {
        logic                               seen;
        logic signed [bei_pkg::POWER_W-1:0] power;
        logic signed [bei_pkg::WH_W-1:0]    drive_wh;
        logic signed [bei_pkg::WH_W-1:0]    charge_wh;
        logic [bei_pkg::SPEED_W-1:0]        speed;
    } reading_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Block inputs, known from time zero
    logic                              cfg_write_en    = 1'b0;
    logic [bei_pkg::CFG_IDX_W-1:0]     cfg_index       = bei_pkg::CFG_SPEED_ID;
    logic [bei_pkg::CFG_DATA_W-1:0]    cfg_data        = '0;
    logic                              in_valid        = 1'b0;
    logic [bei_pkg::ID_W-1:0]          frame_id        = '0;
    logic [bei_pkg::BYTE_W-1:0]        speed_low_byte  = '0;
    logic [bei_pkg::BYTE_W-1:0]        speed_high_byte = '0;
    logic [bei_pkg::VOLT_W-1:0]        pack_voltage    = '0;
    logic signed [bei_pkg::CUR_W-1:0]  pack_current    = '0;
    logic                              out_ready       = 1'b0;

    // Block outputs
    logic                               in_ready;
    logic                               out_valid;
    logic                               battery_frame_seen;
    logic signed [bei_pkg::POWER_W-1:0] power_now;
    logic signed [bei_pkg::WH_W-1:0]    drive_energy_wh;
    logic signed [bei_pkg::WH_W-1:0]    charge_energy_wh;
    logic [bei_pkg::SPEED_W-1:0]        speed_now;

    battery_energy_integrator #(
        .ENERGY_SCALE(bei_pkg::ENERGY_SCALE_DEF)
    ) DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .frame_id           (frame_id),
        .speed_low_byte     (speed_low_byte),
        .speed_high_byte    (speed_high_byte),
        .pack_voltage       (pack_voltage),
        .pack_current       (pack_current),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .battery_frame_seen (battery_frame_seen),
        .power_now          (power_now),
        .drive_energy_wh    (drive_energy_wh),
        .charge_energy_wh   (charge_energy_wh),
        .speed_now          (speed_now)
    );

    // Register copies and energy state tracked alongside the block
    logic [bei_pkg::ID_W-1:0]           speed_id     = '0;
    logic [bei_pkg::ID_W-1:0]           battery_id   = '0;
    logic [bei_pkg::SPEED_W-1:0]        moving_limit = bei_pkg::THRESHOLD_RESET;
    logic [bei_pkg::SPEED_W-1:0]        speed_raw    = '0;
    logic signed [bei_pkg::POWER_W-1:0] power_last   = '0;
    longint                             drive_res    = 0;
    longint                             charge_res   = 0;
    logic signed [bei_pkg::WH_W-1:0]    drive_count  = '0;
    logic signed [bei_pkg::WH_W-1:0]    charge_count = '0;

    reading_t pending_readings[$];

    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  no_idle     = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Add power to a residual, pull it back into [-S, S] and step its counter
    task automatic fold_residual(inout longint res,
                                 inout logic signed [bei_pkg::WH_W-1:0] wh,
                                 input longint pw);
        longint r;
        longint k;
        r = res + pw;
        if (r > SCALE)
        begin
            k  = (r - 1) / SCALE;
            r  = r - k * SCALE;
            wh = wh + k[bei_pkg::WH_W-1:0];
        end
        else if (r < -SCALE)
        begin
            k  = (-r - 1) / SCALE;
            r  = r + k * SCALE;
            wh = wh - k[bei_pkg::WH_W-1:0];
        end
        res = r;
    endtask

    // Apply one transferred frame to the tracked state and queue the expected reading
    task automatic account_frame(input logic [bei_pkg::ID_W-1:0] id,
                                 input logic [bei_pkg::BYTE_W-1:0] lo,
                                 input logic [bei_pkg::BYTE_W-1:0] hi,
                                 input logic [bei_pkg::VOLT_W-1:0] volt,
                                 input logic signed [bei_pkg::CUR_W-1:0] cur);
        reading_t rd;
        longint   pw;
        rd.seen = 1'b0;
        if (id == speed_id)
        begin
            speed_raw = {hi[5:0], lo};
        end
        else if (id == battery_id)
        begin
            rd.seen    = 1'b1;
            pw         = longint'(volt) * longint'(cur);
            power_last = pw[bei_pkg::POWER_W-1:0];
            if (speed_raw > moving_limit || pw > 0)
            begin
                fold_residual(drive_res, drive_count, pw);
            end
            else
            begin
                fold_residual(charge_res, charge_count, pw);
            end
        end
        rd.power     = power_last;
        rd.drive_wh  = drive_count;
        rd.charge_wh = charge_count;
        rd.speed     = speed_raw;
        pending_readings.push_back(rd);
    endtask

    // Present one frame and hold it until the transfer
    task automatic send_frame(input logic [bei_pkg::ID_W-1:0] id,
                              input logic [bei_pkg::BYTE_W-1:0] lo,
                              input logic [bei_pkg::BYTE_W-1:0] hi,
                              input logic [bei_pkg::VOLT_W-1:0] volt,
                              input logic signed [bei_pkg::CUR_W-1:0] cur);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        frame_id        <= id;
        speed_low_byte  <= lo;
        speed_high_byte <= hi;
        pack_voltage    <= volt;
        pack_current    <= cur;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        account_frame(id, lo, hi, volt, cur);
    endtask

    // Drop valid, drain every pending reading, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges
    task automatic write_regs(input logic [bei_pkg::ID_W-1:0] spd,
                              input logic [bei_pkg::ID_W-1:0] bat,
                              input logic [bei_pkg::SPEED_W-1:0] thr);
        speed_id     = spd;
        battery_id   = bat;
        moving_limit = thr;
        cfg_write_en <= 1'b1;
        cfg_index    <= bei_pkg::CFG_SPEED_ID;
        cfg_data     <= bei_pkg::CFG_DATA_W'(spd);
        @(posedge clk);
        cfg_index    <= bei_pkg::CFG_BATTERY_ID;
        cfg_data     <= bei_pkg::CFG_DATA_W'(bat);
        @(posedge clk);
        cfg_index    <= bei_pkg::CFG_MOVING_THRES;
        cfg_data     <= bei_pkg::CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Mix of speed frames, battery frames and stray identifiers
    task automatic send_random_frame();
        int                                pick;
        int                                v;
        logic [bei_pkg::ID_W-1:0]          id;
        logic [bei_pkg::BYTE_W-1:0]        lo;
        logic [bei_pkg::BYTE_W-1:0]        hi;
        logic [bei_pkg::VOLT_W-1:0]        volt;
        logic signed [bei_pkg::CUR_W-1:0]  cur;
        lo   = bei_pkg::BYTE_W'($urandom_range(0, 255));
        hi   = bei_pkg::BYTE_W'($urandom_range(0, 255));
        volt = bei_pkg::VOLT_W'($urandom_range(0, 65535));
        cur  = bei_pkg::CUR_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            id = speed_id;
            case ($urandom_range(0, 2))
                0: ;
                1:
                begin
                    lo = bei_pkg::BYTE_W'($urandom_range(0, 20));
                    hi = bei_pkg::BYTE_W'($urandom_range(0, 3)) << 6;
                end
                default:
                begin
                    // land just around the moving threshold
                    v = int'(moving_limit) + int'($urandom_range(0, 2)) - 1;
                    if (v < 0) v = 0;
                    if (v > 16383) v = 16383;
                    lo = v[7:0];
                    hi = {2'($urandom_range(0, 3)), v[13:8]};
                end
            endcase
        end
        else if (pick < 88)
        begin
            id = battery_id;
            if ($urandom_range(0, 3) != 0)
            begin
                volt = bei_pkg::VOLT_W'($urandom_range(2500, 4500));
            end
            if ($urandom_range(0, 4) != 0)
            begin
                v   = int'($urandom_range(0, 6000)) - 3000;
                cur = v[bei_pkg::CUR_W-1:0];
            end
        end
        else
        begin
            id = bei_pkg::ID_W'($urandom_range(0, 2047));
        end
        send_frame(id, lo, hi, volt, cur);
    endtask

    task automatic run_phase(input logic [bei_pkg::ID_W-1:0] spd,
                             input logic [bei_pkg::ID_W-1:0] bat,
                             input logic [bei_pkg::SPEED_W-1:0] thr,
                             input int count, input bit quiet);
        wait_idle();
        write_regs(spd, bat, thr);
        no_idle = quiet;
        repeat (count) send_random_frame();
        no_idle = 1'b0;
    endtask

    // Both identifiers at reset are zero: frame 0 must act as a speed frame only
    task automatic test_shared_id_after_reset();
        send_frame(11'd0, 8'h55, 8'h2A, 16'd4000, 16'sd1500);
        send_frame(11'd5, 8'h12, 8'h34, 16'd3000, -16'sd200);
        send_frame(11'd0, 8'hAA, 8'hD5, 16'hFFFF, 16'sh7FFF);
    endtask

    // Field extremes, exact scale boundaries, routing between drive and charge
    task automatic test_boundary_frames();
        wait_idle();
        write_regs(11'h123, 11'h7FF, 14'd10);
        // top bits of byte 1 are ignored
        send_frame(11'h123, 8'hFF, 8'hFF, bei_pkg::VOLT_W'($urandom),
                   bei_pkg::CUR_W'($urandom));
        // drive residual lands exactly on +S, then one more step
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'd3600, 16'sd1000);
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'd1, 16'sd1);
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'hFFFF, 16'sh7FFF);
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'hFFFF, 16'sh8000);
        // unknown frame leaves everything alone
        send_frame(11'h000, 8'($urandom), 8'($urandom), bei_pkg::VOLT_W'($urandom),
                   bei_pkg::CUR_W'($urandom));
        send_frame(11'h123, 8'h00, 8'hC0, bei_pkg::VOLT_W'($urandom),
                   bei_pkg::CUR_W'($urandom));
        // charge residual lands exactly on -S, then one more step
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'd3600, -16'sd1000);
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'd1, -16'sd1);
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'd0, 16'sh7FFF);
        // positive power counts as drive even when stopped
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'd3600, 16'sd1000);
        // speed equal to threshold is still stopped
        send_frame(11'h123, 8'd10, 8'h00, bei_pkg::VOLT_W'($urandom),
                   bei_pkg::CUR_W'($urandom));
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'hFFFF, 16'sh8000);
        send_frame(11'h123, 8'd11, 8'h00, bei_pkg::VOLT_W'($urandom),
                   bei_pkg::CUR_W'($urandom));
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'd4000, -16'sd2000);
        send_frame(11'h7FF, 8'($urandom), 8'($urandom), 16'hFFFF, -16'sd1);
    endtask

    task automatic test_random_config();
        run_phase(bei_pkg::ID_W'($urandom_range(0, 2047)),
                  bei_pkg::ID_W'($urandom_range(0, 2047)),
                  bei_pkg::SPEED_W'($urandom_range(0, 40)), 300, 1'b0);
        run_phase(bei_pkg::ID_W'($urandom_range(0, 2047)),
                  bei_pkg::ID_W'($urandom_range(0, 2047)),
                  bei_pkg::SPEED_W'($urandom_range(0, 16383)), 250, 1'b0);
    endtask

    task automatic test_extreme_config();
        run_phase(11'h7FF, 11'h000, 14'h3FFF, 200, 1'b0);
        run_phase(11'h000, 11'h7FF, 14'h0000, 200, 1'b1);
    endtask

    task automatic test_shared_id_random();
        logic [bei_pkg::ID_W-1:0] id;
        id = bei_pkg::ID_W'($urandom_range(0, 2047));
        run_phase(id, id, bei_pkg::SPEED_W'($urandom_range(0, 16383)), 50, 1'b0);
    endtask

    // Result side: stall at random
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_gap();
            end
        end
    end

    // Compare each result transfer with the oldest expected reading
    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, 0);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (battery_frame_seen !== want.seen)
                    report_mismatch("battery_frame_seen", battery_frame_seen, want.seen);
                if (power_now !== want.power)
                    report_mismatch("power_now", power_now, want.power);
                if (drive_energy_wh !== want.drive_wh)
                    report_mismatch("drive_energy_wh", drive_energy_wh, want.drive_wh);
                if (charge_energy_wh !== want.charge_wh)
                    report_mismatch("charge_energy_wh", charge_energy_wh, want.charge_wh);
                if (speed_now !== want.speed)
                    report_mismatch("speed_now", speed_now, want.speed);
            end
        end
    end

    // End the run if nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_shared_id_after_reset();
        test_boundary_frames();
        test_random_config();
        test_extreme_config();
        test_shared_id_random();
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bei_pkg.sv
hw/rtl/battery_energy_integrator.sv
bench/testbench.sv
